### hdl/pcc_pkg.sv
// Shared constants for the point/capsule collision test.
`timescale 1ns / 1ps
package pcc_pkg;

    // register indexes on the configuration channel
    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_START_Z = 3'd2;
    localparam logic [2:0] REG_END_X   = 3'd3;
    localparam logic [2:0] REG_END_Y   = 3'd4;
    localparam logic [2:0] REG_END_Z   = 3'd5;
    localparam logic [2:0] REG_RADIUS  = 3'd6;
    localparam int unsigned CFG_IDX_W  = 3;

    // how the closest point is chosen
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_END   = 2'd1,
        MODE_DIV   = 2'd2
    } mode_t;

endpackage

### hdl/point_capsule_collision.sv
// Pipelined point against capsule collision test with closest axis point.
// Throughput: one word per cycle while the result word is taken; the quotient of the projection takes one
// pipeline stage per fraction bit, so the divider sets the depth.
// The whole pipeline holds when the result word is not taken.
// Reset (aresetn low, synchronous) clears the valid bits and capsule registers to zero.
`timescale 1ns / 1ps
module point_capsule_collision #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data,
    // input points
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_x, point_y, point_z (lowest bits first), zero padded
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // closest_x, closest_y, closest_z, hit (lowest bits first), zero padded
    output logic [((3*COORD_WIDTH+8)/8)*8-1:0]  m_tdata
);
    import pcc_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2*W + 2;        // one product of differences
    localparam int NW  = 2*W + 4;        // dot products and remainder
    localparam int MW  = W + F + 2;      // axis times t
    localparam int NS  = F + 10;         // pipeline stages
    localparam int DV0 = 4;              // first divider stage
    localparam int MDW = ((3*W+8)/8)*8;

    typedef struct packed {
        logic [2:0][W-1:0]  p;
        logic [2:0][W:0]    ab;
        logic [2:0][W:0]    ap;
        logic [2:0][PW-1:0] pn;
        logic [2:0][PW-1:0] pd;
        logic [NW-1:0]      num;
        logic [NW-1:0]      den;
        mode_t              mode;
        logic [NW-1:0]      rem;
        logic [F-1:0]       t;
        logic [2:0][MW-1:0] m;
        logic [2:0][W-1:0]  c;
        logic [2:0][W:0]    d;
        logic [2:0][PW-1:0] sq;
        logic [2*W-3:0]     r2;
        logic [NW-1:0]      dist2;
        logic               hit;
    } item_t;

    logic [2:0][W-1:0] start_reg, end_reg;
    logic [W-2:0]      radius_reg;

    item_t stg_reg [NS];
    item_t stg_next[NS];
    logic  [NS-1:0] vld_reg;
    logic  advance;

    assign cfg_ready = 1'b1;
    assign advance   = m_tready || !vld_reg[NS-1];
    assign s_tready  = advance;

    // configuration registers, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            end_reg    <= '0;
            radius_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_START_X: start_reg[0] <= cfg_data;
                REG_START_Y: start_reg[1] <= cfg_data;
                REG_START_Z: start_reg[2] <= cfg_data;
                REG_END_X:   end_reg[0]   <= cfg_data;
                REG_END_Y:   end_reg[1]   <= cfg_data;
                REG_END_Z:   end_reg[2]   <= cfg_data;
                REG_RADIUS:  radius_reg   <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // stage logic
    for (genvar k = 0; k < NS; k++) begin : g_stage
        if (k == 0) begin : g_diff
            always_comb begin
                stg_next[k] = '0;
                for (int i = 0; i < 3; i++) begin
                    stg_next[k].p[i]  = s_tdata[i*W +: W];
                    stg_next[k].ab[i] = (W+1)'($signed(end_reg[i]))
                                      - (W+1)'($signed(start_reg[i]));
                    stg_next[k].ap[i] = (W+1)'($signed(s_tdata[i*W +: W]))
                                      - (W+1)'($signed(start_reg[i]));
                end
            end
        end else if (k == 1) begin : g_prod
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    stg_next[k].pn[i] = PW'($signed(stg_reg[k-1].ap[i])
                                      * $signed(stg_reg[k-1].ab[i]));
                    stg_next[k].pd[i] = PW'($signed(stg_reg[k-1].ab[i])
                                      * $signed(stg_reg[k-1].ab[i]));
                end
            end
        end else if (k == 2) begin : g_dot
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].num = NW'($signed(stg_reg[k-1].pn[0]))
                                + NW'($signed(stg_reg[k-1].pn[1]))
                                + NW'($signed(stg_reg[k-1].pn[2]));
                stg_next[k].den = NW'($signed(stg_reg[k-1].pd[0]))
                                + NW'($signed(stg_reg[k-1].pd[1]))
                                + NW'($signed(stg_reg[k-1].pd[2]));
            end
        end else if (k == 3) begin : g_class
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].rem = stg_reg[k-1].num;
                stg_next[k].t   = '0;
                if (stg_reg[k-1].den == '0 || stg_reg[k-1].num[NW-1]
                        || stg_reg[k-1].num == '0) begin
                    stg_next[k].mode = MODE_START;
                end else if (stg_reg[k-1].num >= stg_reg[k-1].den) begin
                    stg_next[k].mode = MODE_END;
                end else begin
                    stg_next[k].mode = MODE_DIV;
                end
            end
        end else if (k < DV0 + F) begin : g_div
            // one restoring quotient bit per stage
            logic [NW-1:0] shl;
            assign shl = {stg_reg[k-1].rem[NW-2:0], 1'b0};
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                if (shl >= stg_reg[k-1].den) begin
                    stg_next[k].rem = shl - stg_reg[k-1].den;
                    stg_next[k].t   = {stg_reg[k-1].t[F-2:0], 1'b1};
                end else begin
                    stg_next[k].rem = shl;
                    stg_next[k].t   = {stg_reg[k-1].t[F-2:0], 1'b0};
                end
            end
        end else if (k == DV0 + F) begin : g_scale
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    stg_next[k].m[i] = MW'($signed(stg_reg[k-1].ab[i])
                                     * $signed({1'b0, stg_reg[k-1].t}));
                end
            end
        end else if (k == DV0 + F + 1) begin : g_pick
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    case (stg_reg[k-1].mode)
                        MODE_END: stg_next[k].c[i] = end_reg[i];
                        MODE_DIV: stg_next[k].c[i] = start_reg[i]
                            + W'($signed(stg_reg[k-1].m[i]) >>> F);
                        default:  stg_next[k].c[i] = start_reg[i];
                    endcase
                end
            end
        end else if (k == DV0 + F + 2) begin : g_delta
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    stg_next[k].d[i] = (W+1)'($signed(stg_reg[k-1].p[i]))
                                     - (W+1)'($signed(stg_reg[k-1].c[i]));
                end
            end
        end else if (k == DV0 + F + 3) begin : g_square
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    stg_next[k].sq[i] = PW'($signed(stg_reg[k-1].d[i])
                                      * $signed(stg_reg[k-1].d[i]));
                end
                stg_next[k].r2 = (2*W-2)'(radius_reg * radius_reg);
            end
        end else if (k == DV0 + F + 4) begin : g_sum
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].dist2 = NW'(stg_reg[k-1].sq[0]) + NW'(stg_reg[k-1].sq[1])
                                  + NW'(stg_reg[k-1].sq[2]);
            end
        end else begin : g_cmp
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                stg_next[k].hit = NW'(stg_reg[k-1].r2) >= stg_reg[k-1].dist2;
            end
        end
    end

    // advance the whole pipeline, hold it on a stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < NS; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = MDW'({stg_reg[NS-1].hit, stg_reg[NS-1].c[2],
                            stg_reg[NS-1].c[1], stg_reg[NS-1].c[0]});

endmodule

### hdl/pcc_checker.sv
// Port-level checks for the point/capsule collision test.
`timescale 1ns / 1ps
module pcc_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((3*COORD_WIDTH+8)/8)*8-1:0] m_tdata
);
    // input held back only while a result word is stuck
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // pipeline empty right after reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result word shown right after reset");

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    // padding bits above hit stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >> (3*COORD_WIDTH+1)) == '0))
        else $error("padding bits set");

endmodule

bind point_capsule_collision pcc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
